// ----- rtl/shrt_pkg.sv -----
// Package for the hashed name table: operation codes, table entry layout,
// port widths and the name hash fold function.
// No dependencies.
package shrt_pkg;

  // Default table depth
  localparam int unsigned DefMaxEntries = 512;

  // Field widths of the stream items
  localparam int unsigned RankW  = 9;
  localparam int unsigned CountW = 10;

  // Required first two name characters, little-endian pair
  localparam logic [15:0] ZwPrefix = 16'h775a;

  // Operation carried in the input tuser
  typedef enum logic [1:0] {
    OpClear  = 2'd0,
    OpByte   = 2'd1,
    OpCommit = 2'd2,
    OpLookup = 2'd3
  } op_e;

  // One stored table entry
  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] hash;
  } entry_t;

  // Commands from the sequencer to the hash unit
  typedef struct packed {
    logic end_name;
    logic load_byte;
    logic fold_last;
  } hash_cmd_t;

  // Fold one byte pair into the hash: h ^ (pair + ror8(h))
  function automatic logic [31:0] fold(input logic [31:0] h, input logic [15:0] pair);
    logic [31:0] r;
    r = {h[7:0], h[31:8]};
    return h ^ ({16'd0, pair} + r);
  endfunction

endpackage

// ----- rtl/shrt_hash.sv -----
// Name hash unit: seed register, running hash, previous byte and prefix check.
// One shared fold unit, one fold per cycle. Depends on shrt_pkg.
module shrt_hash (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                seed_we_i,
  input  logic [31:0]         seed_i,
  input  shrt_pkg::hash_cmd_t cmd_i,
  input  logic [7:0]          byte_i,
  output logic [31:0]         hash_o,
  output logic                prefix_ok_o
);

  logic [31:0] seed_q;
  logic [31:0] hash_q;
  logic [7:0]  prev_q;
  logic [1:0]  seen_q;
  logic        ok_q;
  logic [15:0] pair;
  logic [31:0] folded;

  // Select the pair: current byte over previous, or zero over previous
  assign pair   = cmd_i.load_byte ? {byte_i, prev_q} : {8'd0, prev_q};
  assign folded = shrt_pkg::fold(hash_q, pair);

  // Seed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (seed_we_i) begin
      seed_q <= seed_i;
    end
  end

  // Advance the running name state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
      prev_q <= '0;
      seen_q <= '0;
      ok_q   <= 1'b0;
    end else if (cmd_i.end_name) begin
      hash_q <= seed_q;
      prev_q <= '0;
      seen_q <= '0;
      ok_q   <= 1'b0;
    end else if (cmd_i.load_byte) begin
      if (seen_q == 2'd0) begin
        hash_q <= seed_q;
      end else begin
        hash_q <= folded;
      end
      if (seen_q == 2'd1) begin
        ok_q <= (pair == shrt_pkg::ZwPrefix);
      end
      prev_q <= byte_i;
      if (seen_q != 2'd2) begin
        seen_q <= seen_q + 2'd1;
      end
    end else if (cmd_i.fold_last) begin
      hash_q <= folded;
    end
  end

  assign hash_o      = hash_q;
  assign prefix_ok_o = ok_q;

  // Prefix can only be set once a pair has been seen
  assert property (@(posedge clk_i) disable iff (!rst_ni) ok_q |-> seen_q != 2'd0)
    else $error("prefix flag set without a byte pair");
  // Name end clears the byte counter
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.end_name |=> seen_q == 2'd0)
    else $error("byte counter not cleared at name end");
  // Only one command per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(cmd_i))
    else $error("conflicting hash commands");

endmodule

// ----- rtl/syscall_hash_rank_table.sv -----
// Hashed name table kept sorted by address. Clear and name byte go straight to the result;
// a byte marked last first takes a second fold through the shared fold unit. A refused
// commit goes straight to the result; an accepted one moves each larger entry down one
// slot, then writes the new entry. Lookup scans up from position 0 to a match or the end
// of the filled entries. Each table compare is a registered read, then a compare. One
// item in flight; a result not yet taken holds the next item. Reset empties table, zeroes seed.
module syscall_hash_rank_table #(
  parameter int unsigned MAX_ENTRIES = shrt_pkg::DefMaxEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: hash seed
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  // Input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // name_byte[7:0], entry_address[39:8], query_hash[71:40]
  input  logic [1:0]  s_axis_tuser,  // operation[1:0]
  input  logic        s_axis_tlast,  // last_byte
  // Result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // rank_index[8:0], entry_count[18:9], zero[23:19]
  output logic [1:0]  m_axis_tuser   // found[0], accepted[1]
);

  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {
    StIdle,
    StFold,
    StInsRd,
    StInsCmp,
    StLkRd,
    StLkCmp,
    StDone
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [IW-1:0]       pos_q, pos_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic [31:0]         addr_q, addr_d;
  logic [31:0]         query_q, query_d;
  logic [IW-1:0]       rank_q, rank_d;
  logic                found_q, found_d;
  logic                acc_q, acc_d;
  logic                ovalid_q, ovalid_d;
  logic [23:0]         odata_q, odata_d;
  logic [1:0]          ouser_q, ouser_d;

  shrt_pkg::hash_cmd_t hash_cmd;
  logic [31:0]         name_hash;
  logic                prefix_ok;

  shrt_pkg::entry_t    mem_q [MAX_ENTRIES];
  shrt_pkg::entry_t    rd_q;
  shrt_pkg::entry_t    mem_wdata;
  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  logic [IW-1:0]       mem_raddr;

  shrt_pkg::op_e       op;
  logic [31:0]         rank_ext;
  logic [31:0]         count_ext;

  assign op            = shrt_pkg::op_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == StIdle);

  // Name hash unit
  shrt_hash u_hash (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_we_i   (cfg_we_i),
    .seed_i      (cfg_wdata_i),
    .cmd_i       (hash_cmd),
    .byte_i      (s_axis_tdata[7:0]),
    .hash_o      (name_hash),
    .prefix_ok_o (prefix_ok)
  );

  // Table memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[mem_raddr];
  end

  assign rank_ext  = 32'(rank_q);
  assign count_ext = 32'(count_q);

  // Sequencer next state
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    pos_d     = pos_q;
    idx_d     = idx_q;
    addr_d    = addr_q;
    query_d   = query_q;
    rank_d    = rank_q;
    found_d   = found_q;
    acc_d     = acc_q;
    ovalid_d  = ovalid_q;
    odata_d   = odata_q;
    ouser_d   = ouser_q;
    hash_cmd  = '0;
    mem_we    = 1'b0;
    mem_waddr = pos_q;
    mem_wdata = '{addr: addr_q, hash: name_hash};
    mem_raddr = pos_q - IW'(1);

    // Drop the result once taken
    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          addr_d  = s_axis_tdata[39:8];
          query_d = s_axis_tdata[71:40];
          rank_d  = '0;
          found_d = 1'b0;
          acc_d   = 1'b0;
          unique case (op)
            shrt_pkg::OpClear: begin
              count_d           = '0;
              hash_cmd.end_name = 1'b1;
              state_d           = StDone;
            end
            shrt_pkg::OpByte: begin
              hash_cmd.load_byte = 1'b1;
              state_d            = s_axis_tlast ? StFold : StDone;
            end
            shrt_pkg::OpCommit: begin
              if (prefix_ok && (count_q < CW'(MAX_ENTRIES))) begin
                pos_d   = IW'(count_q);
                state_d = StInsRd;
              end else begin
                hash_cmd.end_name = 1'b1;
                state_d           = StDone;
              end
            end
            shrt_pkg::OpLookup: begin
              idx_d   = '0;
              rank_d  = IW'(1);
              state_d = (count_q == '0) ? StDone : StLkRd;
            end
          endcase
        end
      end
      StFold: begin
        hash_cmd.fold_last = 1'b1;
        state_d            = StDone;
      end
      StInsRd: begin
        // Place the new entry at the top, or fetch the entry above
        if (pos_q == '0) begin
          mem_we            = 1'b1;
          count_d           = count_q + CW'(1);
          acc_d             = 1'b1;
          hash_cmd.end_name = 1'b1;
          state_d           = StDone;
        end else begin
          state_d = StInsCmp;
        end
      end
      StInsCmp: begin
        mem_we = 1'b1;
        if (rd_q.addr > addr_q) begin
          // Move the larger entry down one slot
          mem_wdata = rd_q;
          pos_d     = pos_q - IW'(1);
          state_d   = StInsRd;
        end else begin
          count_d           = count_q + CW'(1);
          acc_d             = 1'b1;
          hash_cmd.end_name = 1'b1;
          state_d           = StDone;
        end
      end
      StLkRd: begin
        mem_raddr = idx_q;
        state_d   = StLkCmp;
      end
      StLkCmp: begin
        if (rd_q.hash == query_q) begin
          rank_d  = idx_q;
          found_d = 1'b1;
          state_d = StDone;
        end else if ((CW'(idx_q) + CW'(1)) == count_q) begin
          state_d = StDone;
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = StLkRd;
        end
      end
      StDone: begin
        // Load the result once the output register is free
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          odata_d  = {5'd0, count_ext[shrt_pkg::CountW-1:0], rank_ext[shrt_pkg::RankW-1:0]};
          ouser_d  = {acc_q, found_q};
          state_d  = StIdle;
        end
      end
    endcase
  end

  // Hold sequencer state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= '0;
      pos_q    <= '0;
      idx_q    <= '0;
      rank_q   <= '0;
      found_q  <= 1'b0;
      acc_q    <= 1'b0;
      ovalid_q <= 1'b0;
      odata_q  <= '0;
      ouser_q  <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      pos_q    <= pos_d;
      idx_q    <= idx_d;
      rank_q   <= rank_d;
      found_q  <= found_d;
      acc_q    <= acc_d;
      ovalid_q <= ovalid_d;
      odata_q  <= odata_d;
      ouser_q  <= ouser_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    query_q <= query_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

  // Table never overflows
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(MAX_ENTRIES))
    else $error("entry count beyond table depth");
  // Count only steps up by one or clears
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (count_q != $past(count_q)) |-> (count_q == '0 || count_q == $past(count_q) + CW'(1)))
    else $error("entry count jumped");
  // Insertion compare always has an entry above it
  assert property (@(posedge clk_i) disable iff (!rst_ni) state_q == StInsCmp |-> pos_q != '0)
    else $error("insertion compare at top slot");
  // Lookup only reads filled entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      state_q == StLkCmp |-> CW'(idx_q) < count_q)
    else $error("lookup beyond filled entries");
  // A found lookup never reports an empty table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == StDone && found_q) |-> count_q != '0)
    else $error("match reported on empty table");

endmodule
